// ===== design/brtb_pkg.sv =====
// package for the block ring transmit buffer
// ring geometry, op codes, store request and result types; no dependencies
package brtb_pkg;

  localparam int NUM_BLOCKS   = 4;
  localparam int BLOCK_BYTES  = 64;
  localparam int STORE_DEPTH  = NUM_BLOCKS * BLOCK_BYTES;
  localparam int BLK_W        = $clog2(NUM_BLOCKS);
  localparam int LEN_W        = $clog2(BLOCK_BYTES + 1);
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLUSH = 2'd1,
    OP_DONE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic       idle;
    logic [6:0] start_length;
    logic [1:0] start_block;
    logic       start_valid;
    logic       accepted;
  } res_t;

  function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b);
    next_blk = (b == BLK_W'(NUM_BLOCKS - 1)) ? '0 : b + BLK_W'(1);
  endfunction

endpackage

// ===== design/brtb_store.sv =====
// byte store of the block ring, one write and one registered read port
// depends on brtb_pkg
module brtb_store
  import brtb_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/block_ring_transmit_buffer_unit.sv =====
// block ring transmit buffer, top level
// latency: a result is valid the cycle after its input transfer
// throughput: one item per cycle while out_tready holds; the result register frees as it is taken
// reset (rst_n low, synchronous): ring pointers, fill count, block lengths
// and engine state clear; the byte store is not cleared
// depends on brtb_pkg and brtb_store
module block_ring_transmit_buffer_unit
  import brtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data[7:0], read_block[9:8], read_offset[15:10]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // accepted, start_valid, start_block[1:0],
                                  // start_length[6:0], read_data[7:0], idle, zero pad
);

  logic             in_acc;
  op_t              op;
  logic [7:0]       in_data;
  logic [1:0]       in_rblk;
  logic [5:0]       in_rofs;

  logic [BLK_W-1:0] tail_r, tail_nxt;
  logic [BLK_W-1:0] send_r, send_nxt;
  logic [BLK_W-1:0] act_idx_r, act_idx_nxt;
  logic             act_v_r, act_v_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] len_r [NUM_BLOCKS];
  logic [LEN_W-1:0] len_nxt [NUM_BLOCKS];

  logic             out_valid_r;
  res_t             res_r, res_nxt;
  logic             rd_sel_r, rd_sel_nxt;
  logic [7:0]       rdata;
  logic [7:0]       read_data;
  store_req_t       req_nxt, store_req;

  logic [BLK_W-1:0] nb;
  logic             blocked;
  logic             try_start;
  logic             stop_if_empty;
  logic             tail_full;

  assign in_acc  = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign op      = op_t'(in_tuser);
  assign in_data = in_tdata[7:0];
  assign in_rblk = in_tdata[9:8];
  assign in_rofs = in_tdata[15:10];

  assign nb        = next_blk(tail_r);
  assign blocked   = (nb == send_r) || (act_v_r && (nb == act_idx_r));
  assign tail_full = (fill_r == LEN_W'(BLOCK_BYTES - 1));

  always_comb begin
    tail_nxt      = tail_r;
    send_nxt      = send_r;
    act_idx_nxt   = act_idx_r;
    act_v_nxt     = act_v_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    try_start     = 1'b0;
    stop_if_empty = 1'b0;
    req_nxt       = '0;
    rd_sel_nxt    = 1'b0;
    res_nxt       = '0;
    res_nxt.accepted = 1'b1;

    unique case (op)
      OP_WRITE: begin
        if (tail_full && blocked) begin
          res_nxt.accepted = 1'b0;
          try_start        = !act_v_r;
        end else begin
          req_nxt.we    = 1'b1;
          req_nxt.waddr = ADDR_W'(tail_r) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(fill_r);
          req_nxt.wdata = in_data;
          if (tail_full) begin
            len_nxt[tail_r] = LEN_W'(BLOCK_BYTES);
            tail_nxt        = nb;
            fill_nxt        = '0;
            try_start       = !act_v_r;
          end else begin
            fill_nxt = fill_r + LEN_W'(1);
          end
        end
      end
      OP_FLUSH: begin
        if (fill_r == '0) begin
          try_start = !act_v_r;
        end else if (blocked) begin
          res_nxt.accepted = 1'b0;
          try_start        = !act_v_r;
        end else begin
          len_nxt[tail_r] = fill_r;
          tail_nxt        = nb;
          fill_nxt        = '0;
          try_start       = !act_v_r;
        end
      end
      OP_DONE: begin
        try_start     = act_v_r;
        stop_if_empty = act_v_r;
      end
      OP_READ: begin
        if ((32'(in_rblk) < NUM_BLOCKS) && (32'(in_rofs) < BLOCK_BYTES)) begin
          req_nxt.re    = 1'b1;
          req_nxt.raddr = ADDR_W'(in_rblk) * ADDR_W'(BLOCK_BYTES) + ADDR_W'(in_rofs);
          rd_sel_nxt    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (try_start && (send_r != tail_nxt)) begin
      act_idx_nxt          = send_r;
      act_v_nxt            = 1'b1;
      res_nxt.start_valid  = 1'b1;
      res_nxt.start_block  = 2'(send_r);
      res_nxt.start_length = 7'(len_nxt[send_r]);
      send_nxt             = next_blk(send_r);
    end else if (stop_if_empty) begin
      act_v_nxt = 1'b0;
    end

    res_nxt.idle = (send_nxt == tail_nxt) && !act_v_nxt;
  end

  assign store_req = in_acc ? req_nxt : '0;

  brtb_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      send_r      <= '0;
      act_idx_r   <= '0;
      act_v_r     <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        tail_r      <= tail_nxt;
        send_r      <= send_nxt;
        act_idx_r   <= act_idx_nxt;
        act_v_r     <= act_v_nxt;
        fill_r      <= fill_nxt;
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r    <= res_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  assign read_data  = rd_sel_r ? rdata : 8'h00;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.idle, read_data, res_r.start_length,
                       res_r.start_block, res_r.start_valid, res_r.accepted};

`ifndef SYNTHESIS
  a_fill_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < LEN_W'(BLOCK_BYTES))
    else $error("fill count reached a full block");

  a_refused_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !res_nxt.accepted |=> $stable(fill_r) && $stable(tail_r))
    else $error("refused item changed the tail block");

  a_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.start_valid |=> act_v_r && (act_idx_r == $past(send_r)))
    else $error("block start did not mark the engine active");
`endif

endmodule
